// ===== hdl/tga_rle_pixel_decoder_unit_defines.svh =====
// Assertion macros shared by the TGA RLE pixel decoder modules.
`ifndef TGA_RLE_PIXEL_DECODER_UNIT_DEFINES_SVH
`define TGA_RLE_PIXEL_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define TRD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define TRD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/trd_pkg.sv =====
// Types, constants and register codes of the TGA RLE pixel decoder.
`timescale 1ns / 1ps

package trd_pkg;

	// Result queue depth between decoder and output stage
	localparam int QUEUE_DEPTH = 2;

	// Configuration port
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	// Configuration reset values
	localparam logic [15:0] WIDTH_RST  = 16'd1;
	localparam logic [15:0] HEIGHT_RST = 16'd1;
	localparam logic [2:0]  BPP_RST    = 3'd3;
	localparam logic        MODE_RST   = 1'b1;
	localparam logic [31:0] TOTAL_RST  = 32'(WIDTH_RST) * 32'(HEIGHT_RST);

	// Packet header decode
	localparam logic [7:0] RUN_BIAS = 8'd127;
	localparam logic [2:0] BPP_FOUR = 3'd4;

	// Register indexes (byte address / 4)
	typedef enum logic [1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_BPP    = 2'd2,
		REG_MODE   = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [15:0] image_width;
		logic [15:0] image_height;
		logic [2:0]  bytes_per_pixel;
		logic        compressed_mode;
		// width times height, updated together with the size registers
		logic [31:0] image_total;
	} cfg_t;

	// One decoded run
	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic [7:0] repeat_count;
		logic       last_run;
		logic       run_clamped;
	} res_t;

	// Queue status seen by the decoder and the output stage
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

// ===== hdl/trd_regs.sv =====
// Configuration register file with an APB-style access port.
`timescale 1ns / 1ps

module trd_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [trd_pkg::PADDR_W-1:0] paddr,
	input  logic [trd_pkg::PDATA_W-1:0] pwdata,
	output logic [trd_pkg::PDATA_W-1:0] prdata,
	output trd_pkg::cfg_t               cfg
);

	trd_pkg::cfg_t    cfg_q;
	trd_pkg::reg_idx_t idx;
	logic             wr_en;

	assign idx   = trd_pkg::reg_idx_t'(paddr[3:2]);
	assign wr_en = psel && penable && pwrite;

	// Register writes; the pixel total follows each size write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width     <= trd_pkg::WIDTH_RST;
			cfg_q.image_height    <= trd_pkg::HEIGHT_RST;
			cfg_q.bytes_per_pixel <= trd_pkg::BPP_RST;
			cfg_q.compressed_mode <= trd_pkg::MODE_RST;
			cfg_q.image_total     <= trd_pkg::TOTAL_RST;
		end else if (wr_en) begin
			case (idx)
				trd_pkg::REG_WIDTH: begin
					cfg_q.image_width <= pwdata[15:0];
					cfg_q.image_total <= {16'd0, pwdata[15:0]} *
					                     {16'd0, cfg_q.image_height};
				end
				trd_pkg::REG_HEIGHT: begin
					cfg_q.image_height <= pwdata[15:0];
					cfg_q.image_total  <= {16'd0, cfg_q.image_width} *
					                      {16'd0, pwdata[15:0]};
				end
				trd_pkg::REG_BPP:    cfg_q.bytes_per_pixel <= pwdata[2:0];
				trd_pkg::REG_MODE:   cfg_q.compressed_mode <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		prdata = '0;
		case (idx)
			trd_pkg::REG_WIDTH:  prdata = {16'd0, cfg_q.image_width};
			trd_pkg::REG_HEIGHT: prdata = {16'd0, cfg_q.image_height};
			trd_pkg::REG_BPP:    prdata = {29'd0, cfg_q.bytes_per_pixel};
			trd_pkg::REG_MODE:   prdata = {31'd0, cfg_q.compressed_mode};
			default:             prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

// ===== hdl/trd_front.sv =====
// Decoder front end: takes bytes, parses packet headers, assembles pixels, emits runs.
`timescale 1ns / 1ps
`include "tga_rle_pixel_decoder_unit_defines.svh"

module trd_front (
	input  logic            clk,
	input  logic            arst_n,
	input  trd_pkg::cfg_t   cfg,
	input  logic            data_valid,
	output logic            data_stall,
	input  logic [7:0]      data_byte,
	input  trd_pkg::q_stat_t q_stat,
	output logic            res_valid,
	output trd_pkg::res_t   res_item
);

	// Decoder state
	logic        expect_header_q;
	logic        run_packet_q;
	logic [7:0]  left_q;
	logic [1:0]  bip_q;
	logic [23:0] color_q;
	logic [7:0]  alpha_q;
	logic [31:0] done_q;

	logic        accept;
	logic        is_header;
	logic        bpp4;
	logic        pixel_end;
	logic [23:0] color_nx;
	logic [7:0]  alpha_nx;
	logic [31:0] remaining;
	logic [7:0]  left_eff;
	logic [7:0]  count;
	logic        last;
	logic        clamped;
	logic [31:0] done_add;

	assign data_stall = q_stat.full;
	assign accept     = data_valid && !data_stall;
	assign is_header  = cfg.compressed_mode && expect_header_q;
	assign bpp4       = (cfg.bytes_per_pixel == trd_pkg::BPP_FOUR);
	assign pixel_end  = bpp4 ? (bip_q == 2'd3) : (bip_q >= 2'd2);

	// Pixel byte gather
	always_comb begin
		color_nx = color_q;
		alpha_nx = alpha_q;
		case (bip_q)
			2'd0: begin
				color_nx = {16'd0, data_byte};
				alpha_nx = 8'd0;
			end
			2'd1: color_nx = color_q | {8'd0, data_byte, 8'd0};
			2'd2: color_nx = color_q | {data_byte, 16'd0};
			2'd3: alpha_nx = data_byte;
			default: ;
		endcase
	end

	// Run sizing against the pixels that remain
	always_comb begin
		remaining = (cfg.image_total > done_q) ? (cfg.image_total - done_q) : 32'd1;
		left_eff  = (left_q == 8'd0) ? 8'd1 : left_q;
		count     = 8'd1;
		clamped   = 1'b0;
		last      = (remaining == 32'd1);
		if (cfg.compressed_mode) begin
			if (run_packet_q) begin
				clamped = ({24'd0, left_eff} > remaining);
				count   = clamped ? remaining[7:0] : left_eff;
				last    = ({24'd0, count} == remaining);
			end else begin
				clamped = last && (left_eff > 8'd1);
			end
		end
		done_add = done_q + {24'd0, count};
	end

	assign res_valid = accept && !is_header && pixel_end;

	always_comb begin
		res_item.red          = color_nx[23:16];
		res_item.green        = color_nx[15:8];
		res_item.blue         = color_nx[7:0];
		res_item.alpha        = alpha_nx;
		res_item.repeat_count = count;
		res_item.last_run     = last;
		res_item.run_clamped  = clamped;
	end

	// State update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_header_q <= 1'b1;
			run_packet_q    <= 1'b0;
			left_q          <= 8'd0;
			bip_q           <= 2'd0;
			color_q         <= 24'd0;
			alpha_q         <= 8'd0;
			done_q          <= 32'd0;
		end else if (accept) begin
			if (is_header) begin
				run_packet_q    <= data_byte[7];
				left_q          <= data_byte[7] ? (data_byte - trd_pkg::RUN_BIAS)
				                                : (data_byte + 8'd1);
				expect_header_q <= 1'b0;
				bip_q           <= 2'd0;
			end else if (!pixel_end) begin
				color_q <= color_nx;
				alpha_q <= alpha_nx;
				bip_q   <= bip_q + 2'd1;
			end else if (last) begin
				// image complete: back to start
				expect_header_q <= 1'b1;
				run_packet_q    <= 1'b0;
				left_q          <= 8'd0;
				bip_q           <= 2'd0;
				color_q         <= 24'd0;
				alpha_q         <= 8'd0;
				done_q          <= 32'd0;
			end else begin
				color_q <= color_nx;
				alpha_q <= alpha_nx;
				bip_q   <= 2'd0;
				done_q  <= done_add;
				if (cfg.compressed_mode) begin
					if (run_packet_q) begin
						left_q          <= 8'd0;
						expect_header_q <= 1'b1;
					end else begin
						left_q          <= left_eff - 8'd1;
						expect_header_q <= (left_eff == 8'd1);
					end
				end
			end
		end
	end

	`TRD_ASSERT_NEXT(a_clear_after_last, res_valid && res_item.last_run,
		expect_header_q && (done_q == 32'd0) && (bip_q == 2'd0),
		"decoder state not cleared after last run")
	`TRD_ASSERT_NOW(a_clamp_is_last, res_valid && res_item.run_clamped,
		res_item.last_run, "clamped run not marked last")
	`TRD_ASSERT_NOW(a_count_nonzero, res_valid,
		(res_item.repeat_count != 8'd0) && (res_item.repeat_count <= 8'd128),
		"repeat count out of range")

endmodule

// ===== hdl/trd_queue.sv =====
// Small flop-based queue of decoded runs between decoder and output stage.
`timescale 1ns / 1ps
`include "tga_rle_pixel_decoder_unit_defines.svh"

module trd_queue #(
	parameter int DEPTH = trd_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  trd_pkg::res_t    push_item,
	input  logic             pop,
	output trd_pkg::res_t    head,
	output trd_pkg::q_stat_t q_stat
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	trd_pkg::res_t   mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign q_stat.full  = (count_q == CW'(DEPTH));
	assign q_stat.empty = (count_q == '0);
	assign head         = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	`TRD_ASSERT_NOW(a_no_overflow, push, !q_stat.full, "push into full queue")
	`TRD_ASSERT_NOW(a_no_underflow, pop, !q_stat.empty, "pop from empty queue")
	`TRD_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CW'(DEPTH), "queue count past depth")

endmodule

// ===== hdl/trd_back.sv =====
// Output stage: drains the run queue into the registered result channel.
`timescale 1ns / 1ps

module trd_back (
	input  logic             clk,
	input  logic             arst_n,
	input  trd_pkg::res_t    head,
	input  trd_pkg::q_stat_t q_stat,
	output logic             pop,
	output logic             result_valid,
	input  logic             result_stall,
	output trd_pkg::res_t    result_item
);

	logic          valid_q;
	trd_pkg::res_t item_q;

	// Load when the output register is empty or being taken
	assign pop = !q_stat.empty && (!valid_q || !result_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || !result_stall) begin
			valid_q <= !q_stat.empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_q <= head;
		end
	end

	assign result_valid = valid_q;
	assign result_item  = item_q;

endmodule

// ===== hdl/tga_rle_pixel_decoder_unit.sv =====
// Top level of the TGA run-length pixel decoder.
`timescale 1ns / 1ps
// Usage:
//   Input channel (data_valid / data_stall / data_byte) takes the pixel data
//   of a TGA image, one byte per item, one item per cycle while data_stall is low.
//   Output channel (result_valid / result_stall and the color fields) gives one
//   item per run: red, green, blue, alpha, repeat_count, last_run, run_clamped.
//   Width, height, bytes per pixel and mode sit in APB registers at byte
//   addresses 0, 4, 8 and 12; write them only while the block is idle.
// Timing:
//   The byte that completes a pixel puts its result into the run queue, and
//   from there it moves into the output register.
//   Throughput is one byte per cycle while data_stall is low.
//   A run queue of QUEUE_DEPTH items sits between decoder and output register;
//   when the receiver stalls, the queue fills and then data_stall rises.
// Reset:
//   arst_n clears the decoder to wait for a packet header and loads the
//   registers with width 1, height 1, 3 bytes per pixel, compressed mode.
//   After the last pixel of an image the decoder returns to that start state.

module tga_rle_pixel_decoder_unit #(
	parameter int QUEUE_DEPTH = trd_pkg::QUEUE_DEPTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [trd_pkg::PADDR_W-1:0] paddr,
	input  logic [trd_pkg::PDATA_W-1:0] pwdata,
	output logic [trd_pkg::PDATA_W-1:0] prdata,
	output logic                        pready,
	// byte input
	input  logic                        data_valid,
	output logic                        data_stall,
	input  logic [7:0]                  data_byte,
	// run output
	output logic                        result_valid,
	input  logic                        result_stall,
	output logic [7:0]                  red,
	output logic [7:0]                  green,
	output logic [7:0]                  blue,
	output logic [7:0]                  alpha,
	output logic [7:0]                  repeat_count,
	output logic                        last_run,
	output logic                        run_clamped
);

	trd_pkg::cfg_t    cfg;
	trd_pkg::q_stat_t q_stat;
	trd_pkg::res_t    res_item;
	trd_pkg::res_t    head;
	trd_pkg::res_t    out_item;
	logic             res_valid;
	logic             pop;

	assign pready = 1'b1;

	trd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	trd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.data_valid (data_valid),
		.data_stall (data_stall),
		.data_byte  (data_byte),
		.q_stat     (q_stat),
		.res_valid  (res_valid),
		.res_item   (res_item)
	);

	trd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_item (res_item),
		.pop       (pop),
		.head      (head),
		.q_stat    (q_stat)
	);

	trd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.q_stat       (q_stat),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_item  (out_item)
	);

	// Output fields
	assign red          = out_item.red;
	assign green        = out_item.green;
	assign blue         = out_item.blue;
	assign alpha        = out_item.alpha;
	assign repeat_count = out_item.repeat_count;
	assign last_run     = out_item.last_run;
	assign run_clamped  = out_item.run_clamped;

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the TGA RLE pixel decoder: directed and random byte streams.
`timescale 1ns / 1ps

module tb;

	// clock, reset and block ports
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [trd_pkg::PADDR_W-1:0] paddr = '0;
	logic [trd_pkg::PDATA_W-1:0] pwdata = '0;
	logic [trd_pkg::PDATA_W-1:0] prdata;
	logic pready;
	logic data_valid = 1'b0;
	logic data_stall;
	logic [7:0] data_byte = 8'h00;
	logic result_valid;
	logic result_stall = 1'b0;
	logic [7:0] red, green, blue, alpha, repeat_count;
	logic last_run, run_clamped;

	// decoder model: configuration copy and image state
	logic [15:0] cfg_width = trd_pkg::WIDTH_RST;
	logic [15:0] cfg_height = trd_pkg::HEIGHT_RST;
	logic [2:0] cfg_bpp = trd_pkg::BPP_RST;
	logic cfg_compressed = trd_pkg::MODE_RST;
	logic hdr_wait = 1'b1;
	logic run_pkt = 1'b0;
	int pkt_left = 0;
	int byte_pos = 0;
	logic [23:0] color_acc = '0;
	logic [7:0] alpha_acc = '0;
	logic [31:0] px_done = '0;

	trd_pkg::res_t pending_runs[$];
	int fail_count = 0;
	int bytes_sent = 0;
	int send_idle_pct = 36;
	int recv_idle_pct = 62;

	tga_rle_pixel_decoder_unit dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.data_valid(data_valid), .data_stall(data_stall), .data_byte(data_byte),
		.result_valid(result_valid), .result_stall(result_stall),
		.red(red), .green(green), .blue(blue), .alpha(alpha),
		.repeat_count(repeat_count), .last_run(last_run), .run_clamped(run_clamped)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// back to the start-of-image state
	task automatic clear_image();
		hdr_wait = 1'b1;
		run_pkt = 1'b0;
		pkt_left = 0;
		byte_pos = 0;
		color_acc = '0;
		alpha_acc = '0;
		px_done = '0;
	endtask

	task automatic push_run(input int count, input logic last, input logic clamped);
		trd_pkg::res_t r;
		r.red = color_acc[23:16];
		r.green = color_acc[15:8];
		r.blue = color_acc[7:0];
		r.alpha = alpha_acc;
		r.repeat_count = 8'(count);
		r.last_run = last;
		r.run_clamped = clamped;
		pending_runs.push_back(r);
	endtask

	// expected runs caused by one accepted byte
	task automatic decode_byte(input logic [7:0] b);
		int bpp;
		int count;
		logic [31:0] total;
		logic [31:0] rem;
		logic last;
		logic clamped;
		bpp = (cfg_bpp == trd_pkg::BPP_FOUR) ? 4 : 3;

		// packet header
		if (cfg_compressed && hdr_wait) begin
			if (b < 8'd128) begin
				run_pkt = 1'b0;
				pkt_left = int'(b) + 1;
			end else begin
				run_pkt = 1'b1;
				pkt_left = int'(b) - 127;
			end
			hdr_wait = 1'b0;
			byte_pos = 0;
			return;
		end

		// collect pixel bytes, blue first
		if (byte_pos == 0) begin
			color_acc = {16'h0000, b};
			alpha_acc = 8'h00;
		end else if (byte_pos < 3) begin
			color_acc = color_acc | ({16'h0000, b} << (8 * byte_pos));
		end else begin
			alpha_acc = b;
		end
		if (byte_pos + 1 < bpp) begin
			byte_pos = (byte_pos + 1) & 3;
			return;
		end
		byte_pos = 0;

		// pixels left in the image; at least one once the count is reached
		total = 32'(cfg_width) * 32'(cfg_height);
		rem = (total > px_done) ? total - px_done : 32'd1;

		if (!cfg_compressed) begin
			last = (rem == 32'd1);
			push_run(1, last, 1'b0);
			if (last)
				clear_image();
			else
				px_done = px_done + 1;
			return;
		end

		if (pkt_left == 0)
			pkt_left = 1;

		if (run_pkt) begin
			count = pkt_left;
			clamped = (32'(count) > rem);
			if (clamped)
				count = int'(rem);
			last = (32'(count) == rem);
			push_run(count, last, clamped);
			if (last) begin
				clear_image();
			end else begin
				px_done = px_done + 32'(count);
				pkt_left = 0;
				hdr_wait = 1'b1;
			end
			return;
		end

		// raw packet, one pixel per result
		last = (rem == 32'd1);
		clamped = last && (pkt_left > 1);
		push_run(1, last, clamped);
		if (last) begin
			clear_image();
		end else begin
			px_done = px_done + 1;
			pkt_left = pkt_left - 1;
			if (pkt_left == 0)
				hdr_wait = 1'b1;
		end
	endtask

	// result checker and receiver stall
	always @(posedge clk) begin : check_runs
		trd_pkg::res_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_runs.size() == 0) begin
				$error("result item with no run expected");
				fail_count++;
			end else begin
				want = pending_runs.pop_front();
				if (red !== want.red) begin
					$error("red: expected %0h, got %0h", want.red, red);
					fail_count++;
				end
				if (green !== want.green) begin
					$error("green: expected %0h, got %0h", want.green, green);
					fail_count++;
				end
				if (blue !== want.blue) begin
					$error("blue: expected %0h, got %0h", want.blue, blue);
					fail_count++;
				end
				if (alpha !== want.alpha) begin
					$error("alpha: expected %0h, got %0h", want.alpha, alpha);
					fail_count++;
				end
				if (repeat_count !== want.repeat_count) begin
					$error("repeat_count: expected %0d, got %0d", want.repeat_count, repeat_count);
					fail_count++;
				end
				if (last_run !== want.last_run) begin
					$error("last_run: expected %0b, got %0b", want.last_run, last_run);
					fail_count++;
				end
				if (run_clamped !== want.run_clamped) begin
					$error("run_clamped: expected %0b, got %0b", want.run_clamped, run_clamped);
					fail_count++;
				end
			end
		end
		result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
	end

	// one item on the byte channel, with random gaps before it
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			data_valid <= 1'b0;
			@(posedge clk);
		end
		data_valid <= 1'b1;
		data_byte <= b;
		do @(posedge clk); while (data_stall);
		decode_byte(b);
		bytes_sent++;
	endtask

	task automatic send_pixel(input int nbytes);
		repeat (nbytes) send_byte(8'($urandom_range(0, 255)));
	endtask

	// stop sending until every expected run is out, then let the pipe drain
	task automatic wait_idle();
		data_valid <= 1'b0;
		while (pending_runs.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// APB write: setup, then access
	task automatic write_reg(input trd_pkg::reg_idx_t idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			trd_pkg::REG_WIDTH: cfg_width = val[15:0];
			trd_pkg::REG_HEIGHT: cfg_height = val[15:0];
			trd_pkg::REG_BPP: cfg_bpp = val[2:0];
			trd_pkg::REG_MODE: cfg_compressed = val[0];
			default: ;
		endcase
	endtask

	// reset values: 1x1, three bytes, compressed; run of 128 cut to one pixel
	task automatic test_default_config();
		send_byte(8'h00);
		repeat (3) send_byte(8'h00);
		send_byte(8'hFF);
		repeat (3) send_byte(8'hFF);
	endtask

	// zero width: the next pixel ends the image
	task automatic test_zero_size();
		wait_idle();
		write_reg(trd_pkg::REG_WIDTH, 32'd0);
		write_reg(trd_pkg::REG_HEIGHT, 32'd65535);
		write_reg(trd_pkg::REG_BPP, 32'd4);
		send_byte(8'h80);
		send_byte(8'hAA);
		send_byte(8'h55);
		send_byte(8'hAA);
		send_byte(8'h55);
	endtask

	// largest image, odd pixel size, then shrink under a long raw packet
	task automatic test_size_change();
		wait_idle();
		write_reg(trd_pkg::REG_WIDTH, 32'd65535);
		write_reg(trd_pkg::REG_HEIGHT, 32'd65535);
		write_reg(trd_pkg::REG_BPP, 32'd7);
		send_byte(8'h7F);
		send_byte(8'h12);
		send_byte(8'h34);
		send_byte(8'h56);
		wait_idle();
		write_reg(trd_pkg::REG_WIDTH, 32'd1);
		write_reg(trd_pkg::REG_HEIGHT, 32'd1);
		send_byte(8'h9A);
		send_byte(8'hBC);
		send_byte(8'hDE);
	endtask

	// uncompressed pixels, pixel size code zero
	task automatic test_uncompressed();
		wait_idle();
		write_reg(trd_pkg::REG_MODE, 32'd0);
		write_reg(trd_pkg::REG_BPP, 32'd0);
		write_reg(trd_pkg::REG_WIDTH, 32'd2);
		write_reg(trd_pkg::REG_HEIGHT, 32'd1);
		send_byte(8'h01);
		send_byte(8'h80);
		send_byte(8'h7F);
		send_byte(8'hFE);
		send_byte(8'h02);
		send_byte(8'h40);
	endtask

	// raw packet interrupted by an uncompressed pixel, then resumed
	task automatic test_mode_switch();
		wait_idle();
		write_reg(trd_pkg::REG_MODE, 32'd1);
		write_reg(trd_pkg::REG_WIDTH, 32'd3);
		write_reg(trd_pkg::REG_BPP, 32'd3);
		send_byte(8'h01);
		send_pixel(3);
		wait_idle();
		write_reg(trd_pkg::REG_MODE, 32'd0);
		send_pixel(3);
		wait_idle();
		write_reg(trd_pkg::REG_MODE, 32'd1);
		send_pixel(3);
	endtask

	// one well-formed image with random size, format and packets
	task automatic random_image();
		int w, h, bpp_code, bpp_n, px_left, n, take;
		logic comp, is_run;
		w = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 24) : $urandom_range(1, 6);
		h = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 10) : $urandom_range(1, 4);
		bpp_code = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : $urandom_range(3, 4);
		comp = ($urandom_range(0, 9) < 7);
		wait_idle();
		write_reg(trd_pkg::REG_WIDTH, 32'(w));
		write_reg(trd_pkg::REG_HEIGHT, 32'(h));
		write_reg(trd_pkg::REG_BPP, 32'(bpp_code));
		write_reg(trd_pkg::REG_MODE, {31'd0, comp});
		bpp_n = (bpp_code == int'(trd_pkg::BPP_FOUR)) ? 4 : 3;
		px_left = w * h;
		if (!comp) begin
			repeat (px_left) send_pixel(bpp_n);
		end else begin
			while (px_left > 0) begin
				is_run = 1'($urandom_range(0, 1));
				// now and then a packet longer than what is left
				if ($urandom_range(0, 9) == 0)
					n = $urandom_range(1, 128);
				else
					n = $urandom_range(1, (px_left < 128) ? px_left : 128);
				take = (n < px_left) ? n : px_left;
				send_byte(is_run ? 8'(n + 127) : 8'(n - 1));
				if (is_run)
					send_pixel(bpp_n);
				else
					repeat (take) send_pixel(bpp_n);
				px_left -= take;
			end
		end
	endtask

	// mostly images, some noise bytes and register writes mid-image
	task automatic random_phase(input int snd_pct, input int rcv_pct, input int n_bytes);
		int start;
		int pick;
		send_idle_pct = snd_pct;
		recv_idle_pct = rcv_pct;
		start = bytes_sent;
		while (bytes_sent - start < n_bytes) begin
			pick = $urandom_range(0, 9);
			if (pick < 8) begin
				random_image();
			end else if (pick == 8) begin
				repeat ($urandom_range(1, 20)) send_byte(8'($urandom_range(0, 255)));
			end else begin
				wait_idle();
				write_reg(trd_pkg::reg_idx_t'($urandom_range(0, 3)), $urandom);
			end
		end
	endtask

	task automatic test_random_traffic();
		random_phase(36, 62, 570);
		random_phase(62, 36, 570);
		random_phase(0, 0, 570);
	endtask

	// main sequence
	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_config();
		test_zero_size();
		test_size_change();
		test_uncompressed();
		test_mode_switch();
		test_random_traffic();
		wait_idle();
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// watchdog
	initial begin
		#5000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/trd_pkg.sv
hdl/trd_regs.sv
hdl/trd_front.sv
hdl/trd_queue.sv
hdl/trd_back.sv
hdl/tga_rle_pixel_decoder_unit.sv
tb/tb.sv
